// ===== rtl/core/ple_pkg.sv =====
// Package for the positional list engine: command codes, status codes, state encoding.
// No dependencies.
`timescale 1ns / 1ps
package ple_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ      = 3'd6,
    OP_NONE      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_FETCH = 10'b00_0000_0010,
    S_WALK  = 10'b00_0000_0100,
    S_LINK  = 10'b00_0000_1000,
    S_A_RD  = 10'b00_0001_0000,
    S_A_WR  = 10'b00_0010_0000,
    S_B_RD  = 10'b00_0100_0000,
    S_B_WR  = 10'b00_1000_0000,
    S_RDATA = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

endpackage

// ===== rtl/core/ple_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Positional list engine top level: doubly linked list in a node pool.
// Depends on ple_pkg and ple_ram.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one command word: op, value_in, position.
//   m_axis carries result words: status, value_out, value_valid, is_last,
//   list_count. Each command gives one word, except a read-out of a
//   non-empty list, which gives one word per element with is_last on the
//   final one.
//   The node pool sits in one RAM of {prev, next, value} per node, with
//   a registered read. Every link hop sets the address, then takes the data;
//   each neighbor patch is a read-modify-write.
//   Rejected commands and unused opcodes go straight to the result word;
//   an insert at a position first walks links from the head, and a delete
//   at a position walks from the head to the node; inserts then write the
//   new node, deletes unlink it, and both patch the neighbors. A read-out
//   fetches and sends each element in turn.
//   One command is in work at a time; s_axis_tready is high only while idle.
//   Reset (rst, synchronous) empties the list and frees every node; no
//   clearing pass is needed since unwritten nodes are never read.
//   When m_axis_tready is low the result word is held and the engine waits.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] op, [34:3] value_in, [40:35] position, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] value_out, [34] value_valid, [CW+34:35] list_count
  output logic [(($clog2(DEPTH + 1) + 35 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = AW + 1;                 // link width with null
  localparam int CW = $clog2(DEPTH + 1);      // count width
  localparam int PW = (CW + 1 > 6) ? CW + 1 : 6;  // position compare width
  localparam int EW = 32 + 2 * LW;            // RAM entry
  localparam int OW = ((CW + 35 + 7) / 8) * 8;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  state_t state;

  // Entry layout: [31:0] value, [LW+31:32] next, [EW-1:LW+32] prev
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  ple_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [DEPTH-1:0] free_map;
  logic [LW-1:0]    head, tail;
  logic [CW-1:0]    count;

  op_t           cmd_op;
  logic [31:0]   cmd_val;
  logic [CW-1:0] steps;      // links still to walk, or words left to read
  logic [LW-1:0] ptr;        // node being read
  logic          is_ins;
  logic [AW-1:0] new_node;
  logic [LW-1:0] na, nb;     // neighbors: before and after
  logic [LW-1:0] a_link;     // new next link for na
  logic [LW-1:0] b_link;     // new prev link for nb

  status_t       o_status;
  logic [31:0]   o_val;
  logic          o_vv, o_last;

  // Decode the incoming word
  op_t        in_op;
  logic [5:0] in_pos;
  logic [PW-1:0] pos_ext, cnt_ext, ins_pos;
  logic ins_bad, del_bad;
  assign in_op   = op_t'(s_axis_tdata[2:0]);
  assign in_pos  = s_axis_tdata[40:35];
  assign pos_ext = PW'(in_pos[4:0]);
  assign cnt_ext = PW'(count);
  assign ins_bad = (in_op == OP_INS_AT) && (in_pos[5] || pos_ext > cnt_ext);
  assign del_bad = in_pos[5] || pos_ext >= cnt_ext;

  // Insert position for each insert command
  always_comb begin
    unique case (in_op)
      OP_INS_FRONT: ins_pos = '0;
      OP_INS_BACK:  ins_pos = cnt_ext;
      default:      ins_pos = pos_ext;
    endcase
  end

  // Lowest free node
  logic [AW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  logic full;
  assign full = (count == CW'(DEPTH));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);

  logic [LW-1:0] r_next, r_prev;
  assign r_next = rdata[LW+31:32];
  assign r_prev = rdata[EW-1:LW+32];

  // Read always follows ptr; a read of the entry written the same cycle is never used
  assign raddr = ptr[AW-1:0];

  // Write port: new node, or patched neighbor link
  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = rdata;
    unique case (state)
      S_LINK: begin
        we    = 1'b1;
        waddr = new_node;
        wdata = {na, nb, cmd_val};
      end
      S_A_WR: begin
        we    = 1'b1;
        wdata = {r_prev, a_link, rdata[31:0]};
      end
      S_B_WR: begin
        we    = 1'b1;
        wdata = {b_link, r_next, rdata[31:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      free_map <= '1;
      head     <= NIL;
      tail     <= NIL;
      count    <= '0;
      o_status <= ST_OK;
      o_val    <= '0;
      o_vv     <= 1'b0;
      o_last   <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_op   <= in_op;
            cmd_val  <= s_axis_tdata[34:3];
            new_node <= free_idx;
            o_val    <= '0;
            o_vv     <= 1'b0;
            o_last   <= 1'b1;
            unique case (in_op)
              OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                is_ins <= 1'b1;
                if (ins_bad) begin
                  o_status <= ST_BAD_POS;
                  state    <= S_OUT;
                end else if (full) begin
                  o_status <= ST_FULL;
                  state    <= S_OUT;
                end else if (ins_pos == '0) begin
                  // New head, no walk
                  o_status <= ST_OK;
                  na <= NIL; nb <= head;
                  state <= S_LINK;
                end else if (ins_pos == cnt_ext) begin
                  o_status <= ST_OK;
                  na <= tail; nb <= NIL;
                  state <= S_LINK;
                end else begin
                  // Walk to node before the position
                  o_status <= ST_OK;
                  ptr   <= head;
                  steps <= CW'(ins_pos) - CW'(1);
                  state <= S_FETCH;
                end
              end
              OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                is_ins <= 1'b0;
                if (in_op != OP_DEL_AT && count == '0) begin
                  o_status <= ST_EMPTY;
                  state    <= S_OUT;
                end else if (in_op == OP_DEL_AT && del_bad) begin
                  o_status <= ST_BAD_POS;
                  state    <= S_OUT;
                end else begin
                  o_status <= ST_OK;
                  ptr   <= (in_op == OP_DEL_BACK) ? tail : head;
                  steps <= (in_op == OP_DEL_AT) ? CW'(in_pos[4:0]) : '0;
                  state <= S_FETCH;
                end
              end
              OP_READ: begin
                o_status <= ST_OK;
                if (count != '0) begin
                  ptr   <= head;
                  steps <= count;
                  state <= S_FETCH;
                end else begin
                  state <= S_OUT;
                end
              end
              default: begin
                o_status <= ST_OK;
                state    <= S_OUT;
              end
            endcase
          end
        end
        // RAM latches the entry at ptr
        S_FETCH: begin
          state <= (cmd_op == OP_READ) ? S_RDATA : S_WALK;
        end
        // Advance one link, or act on the node reached
        S_WALK: begin
          if (steps != '0) begin
            ptr   <= r_next;
            steps <= steps - CW'(1);
            state <= S_FETCH;
          end else if (is_ins) begin
            na <= ptr; nb <= r_next;
            state <= S_LINK;
          end else begin
            // Unlink ptr and patch its neighbors to each other
            na <= r_prev; nb <= r_next;
            a_link <= r_next; b_link <= r_prev;
            free_map[ptr[AW-1:0]] <= 1'b1;
            count <= count - CW'(1);
            if (r_prev == NIL) head <= r_next;
            if (r_next == NIL) tail <= r_prev;
            if (r_prev != NIL) begin
              ptr <= r_prev; state <= S_A_RD;
            end else if (r_next != NIL) begin
              ptr <= r_next; state <= S_B_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        // Write the new node and point its neighbors at it
        S_LINK: begin
          free_map[new_node] <= 1'b0;
          count <= count + CW'(1);
          if (na == NIL) head <= LW'(new_node);
          if (nb == NIL) tail <= LW'(new_node);
          a_link <= LW'(new_node);
          b_link <= LW'(new_node);
          if (na != NIL) begin
            ptr <= na; state <= S_A_RD;
          end else if (nb != NIL) begin
            ptr <= nb; state <= S_B_RD;
          end else begin
            state <= S_OUT;
          end
        end
        // Patch next link of na
        S_A_RD: state <= S_A_WR;
        S_A_WR: begin
          if (nb != NIL) begin
            ptr <= nb; state <= S_B_RD;
          end else begin
            state <= S_OUT;
          end
        end
        // Patch prev link of nb
        S_B_RD: state <= S_B_WR;
        S_B_WR: state <= S_OUT;
        // Read-out: capture one element and advance
        S_RDATA: begin
          o_val  <= rdata[31:0];
          o_vv   <= 1'b1;
          o_last <= (steps == CW'(1));
          steps  <= steps - CW'(1);
          ptr    <= r_next;
          state  <= S_OUT;
        end
        // Hold the word until taken
        S_OUT: begin
          if (m_axis_tready) begin
            state <= (cmd_op == OP_READ && !o_last) ? S_FETCH : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = OW'({count, o_vv, o_val, o_status});
  assign m_axis_tlast = o_last;

  // Count never exceeds pool size
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("list count above pool size");
  // Empty list has no head
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> (head == NIL))
    else $error("empty list with head");
  // No input taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid |-> !s_axis_tready)
    else $error("accept while result pending");
  // Stalled result word stays put
  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && !m_axis_tready) |=>
                   (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result word changed while stalled");
  // State register stays one-hot
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

endmodule
